### hw/rtl/osc_rk_pkg.sv
package osc_rk_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 28;

    localparam int STEP_BITS  = 28;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 28'd2684355;

    localparam int STAGES   = 7;
    localparam int NUM_COEF = 28;
    localparam int P_BASE   = 21;

    localparam int H_SHIFT    = 28;
    localparam int COEF_SHIFT = 32;

    typedef enum logic [0:0] {
        OP_ADVANCE = 1'b0,
        OP_LOAD    = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARG_INIT,
        S_MUL_START,
        S_PP,
        S_DRAIN,
        S_SAT,
        S_CONSUME,
        S_UPDATE,
        S_PUBLISH
    } ctl_state_t;

    typedef enum logic [1:0] {
        PH_TERM,
        PH_H,
        PH_WEIGHT
    } phase_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ARG_INIT,
        DP_MUL_K,
        DP_MUL_ARG,
        DP_PP,
        DP_SAT,
        DP_ACC_ARG,
        DP_STORE_K,
        DP_ACC_INC,
        DP_UPDATE,
        DP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] k_idx;
        logic [4:0] coef_idx;
        logic [1:0] limb;
        logic       pass_y;
    } dp_cmd_t;

    // |coefficient| * 2^32, rounded half away from zero; stage rows, then weights
    localparam logic [63:0] COEF_MAG [NUM_COEF] = '{
        ((64'd1 << 33) + 64'd5) / 64'd10,
        ((64'd3 << 33) + 64'd40) / 64'd80,
        ((64'd9 << 33) + 64'd40) / 64'd80,
        ((64'd44 << 33) + 64'd45) / 64'd90,
        ((64'd56 << 33) + 64'd15) / 64'd30,
        ((64'd32 << 33) + 64'd9) / 64'd18,
        ((64'd19372 << 33) + 64'd6561) / 64'd13122,
        ((64'd25360 << 33) + 64'd2187) / 64'd4374,
        ((64'd64448 << 33) + 64'd6561) / 64'd13122,
        ((64'd212 << 33) + 64'd729) / 64'd1458,
        ((64'd9017 << 33) + 64'd3168) / 64'd6336,
        ((64'd355 << 33) + 64'd33) / 64'd66,
        ((64'd46732 << 33) + 64'd5247) / 64'd10494,
        ((64'd49 << 33) + 64'd176) / 64'd352,
        ((64'd5103 << 33) + 64'd18656) / 64'd37312,
        ((64'd35 << 33) + 64'd384) / 64'd768,
        64'd0,
        ((64'd500 << 33) + 64'd1113) / 64'd2226,
        ((64'd125 << 33) + 64'd192) / 64'd384,
        ((64'd2187 << 33) + 64'd6784) / 64'd13568,
        ((64'd11 << 33) + 64'd84) / 64'd168,
        ((64'd5179 << 33) + 64'd57600) / 64'd115200,
        64'd0,
        ((64'd7571 << 33) + 64'd16695) / 64'd33390,
        ((64'd393 << 33) + 64'd640) / 64'd1280,
        ((64'd92097 << 33) + 64'd339200) / 64'd678400,
        ((64'd187 << 33) + 64'd2100) / 64'd4200,
        ((64'd1 << 33) + 64'd40) / 64'd80
    };

    localparam logic [NUM_COEF-1:0] COEF_NEG =
        (28'd1 << 4) | (28'd1 << 7) | (28'd1 << 9) | (28'd1 << 11) |
        (28'd1 << 14) | (28'd1 << 19) | (28'd1 << 25);

endpackage

### hw/rtl/osc_rk_ifs.sv
interface osc_rk_cmd_if;
    import osc_rk_pkg::*;
    logic               valid;
    logic               ready;
    opcode_t            opcode;
    logic signed [31:0] load_pos;
    logic signed [31:0] load_vel;
    modport source (output valid, opcode, load_pos, load_vel, input ready);
    modport sink   (input valid, opcode, load_pos, load_vel, output ready);
endinterface

interface osc_rk_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_value;
    logic signed [31:0] vel_value;
    modport source (output valid, pos_value, vel_value, input ready);
    modport sink   (input valid, pos_value, vel_value, output ready);
endinterface

interface osc_rk_cfg_if;
    import osc_rk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STEP_BITS-1:0] step_size;
    modport source (output valid, step_size, input ready);
    modport sink   (input valid, step_size, output ready);
endinterface

### hw/rtl/osc_rk_ctrl.sv
module osc_rk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  osc_rk_pkg::opcode_t cmd_opcode,
    output logic                cmd_ready,
    output logic                res_valid,
    input  logic                res_ready,
    output osc_rk_pkg::dp_cmd_t dp_cmd
);
    import osc_rk_pkg::*;

    localparam logic [2:0] LAST_STAGE = 3'(STAGES - 1);
    localparam logic [1:0] LAST_LIMB  = 2'd3;

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [2:0] stage_reg, stage_next;
    logic [2:0] term_reg, term_next;
    logic [4:0] cidx_reg, cidx_next;
    logic [1:0] limb_reg, limb_next;
    logic       pass_reg, pass_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_TERM;
            stage_reg     <= '0;
            term_reg      <= '0;
            cidx_reg      <= '0;
            limb_reg      <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            stage_reg     <= stage_next;
            term_reg      <= term_next;
            cidx_reg      <= cidx_next;
            limb_reg      <= limb_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        stage_next     = stage_reg;
        term_next      = term_reg;
        cidx_next      = cidx_reg;
        limb_next      = limb_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !res_ready;
        cmd_ready      = 1'b0;

        dp_cmd.op       = DP_NOP;
        dp_cmd.k_idx    = (phase_reg == PH_TERM) ? term_reg : stage_reg;
        dp_cmd.coef_idx = (phase_reg == PH_WEIGHT) ? 5'(P_BASE) + 5'(stage_reg) : cidx_reg;
        dp_cmd.limb     = limb_reg;
        dp_cmd.pass_y   = pass_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd_opcode == OP_LOAD)
                    begin
                        dp_cmd.op  = DP_LOAD;
                        state_next = S_PUBLISH;
                    end
                    else
                    begin
                        pass_next  = 1'b0;
                        stage_next = '0;
                        cidx_next  = '0;
                        state_next = S_ARG_INIT;
                    end
                end
            end
            S_ARG_INIT:
            begin
                dp_cmd.op  = DP_ARG_INIT;
                term_next  = '0;
                phase_next = (stage_reg == '0) ? PH_H : PH_TERM;
                state_next = S_MUL_START;
            end
            S_MUL_START:
            begin
                dp_cmd.op  = (phase_reg == PH_H) ? DP_MUL_ARG : DP_MUL_K;
                limb_next  = '0;
                state_next = S_PP;
            end
            S_PP:
            begin
                dp_cmd.op = DP_PP;
                limb_next = limb_reg + 2'd1;
                if (limb_reg == LAST_LIMB)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SAT;
            end
            S_SAT:
            begin
                dp_cmd.op  = DP_SAT;
                state_next = S_CONSUME;
            end
            S_CONSUME:
            begin
                unique case (phase_reg)
                    PH_TERM:
                    begin
                        dp_cmd.op  = DP_ACC_ARG;
                        cidx_next  = cidx_reg + 5'd1;
                        term_next  = term_reg + 3'd1;
                        if (3'(term_reg + 3'd1) == stage_reg)
                        begin
                            phase_next = PH_H;
                        end
                        state_next = S_MUL_START;
                    end
                    PH_H:
                    begin
                        dp_cmd.op = DP_STORE_K;
                        if (stage_reg == LAST_STAGE)
                        begin
                            stage_next = '0;
                            phase_next = PH_WEIGHT;
                            state_next = S_MUL_START;
                        end
                        else
                        begin
                            stage_next = stage_reg + 3'd1;
                            state_next = S_ARG_INIT;
                        end
                    end
                    PH_WEIGHT:
                    begin
                        dp_cmd.op = DP_ACC_INC;
                        if (stage_reg == LAST_STAGE)
                        begin
                            state_next = S_UPDATE;
                        end
                        else
                        begin
                            stage_next = stage_reg + 3'd1;
                            state_next = S_MUL_START;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_UPDATE:
            begin
                dp_cmd.op = DP_UPDATE;
                if (!pass_reg)
                begin
                    pass_next  = 1'b1;
                    stage_next = '0;
                    cidx_next  = '0;
                    state_next = S_ARG_INIT;
                end
                else
                begin
                    state_next = S_PUBLISH;
                end
            end
            S_PUBLISH:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    dp_cmd.op      = DP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid = out_valid_reg;

endmodule

### hw/rtl/osc_rk_dp.sv
module osc_rk_dp #(
    parameter int WORD_BITS = osc_rk_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = osc_rk_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  osc_rk_pkg::dp_cmd_t                 dp_cmd,
    input  logic signed [31:0]                  load_pos,
    input  logic signed [31:0]                  load_vel,
    input  logic                                cfg_we,
    input  logic [osc_rk_pkg::STEP_BITS-1:0]    cfg_data,
    output logic signed [31:0]                  pos_value,
    output logic signed [31:0]                  vel_value
);
    import osc_rk_pkg::*;

    localparam int W = WORD_BITS;
    localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0] MAXW64 = 64'(MAXW);
    localparam logic signed [63:0] MINW64 = 64'(MINW);
    localparam logic [63:0] MAXMAG = 64'(MAXW);
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;
    localparam logic signed [W-1:0] VEL_INIT =
        (FRAC_BITS >= W - 1) ? MAXW : W'(1) << FRAC_BITS;

    function automatic logic signed [W-1:0] sat_add(
        input logic signed [W-1:0] a,
        input logic signed [W-1:0] b
    );
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? MINW : MAXW;
        end
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] a);
        return (a == MINW) ? MAXW : -a;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [W-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return v[W-1] ? 64'(-e) : 64'(e);
    endfunction

    function automatic logic signed [W-1:0] load_word(input logic signed [31:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > MAXW64)
        begin
            return MAXW;
        end
        if (e < MINW64)
        begin
            return MINW;
        end
        return W'(e);
    endfunction

    function automatic logic signed [31:0] out_word(input logic signed [W-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > MAX32)
        begin
            return 32'sh7fffffff;
        end
        if (e < MIN32)
        begin
            return 32'sh80000000;
        end
        return 32'(e);
    endfunction

    logic signed [W-1:0] pos_reg, vel_reg;
    logic [STEP_BITS-1:0] h_reg;

    logic signed [W-1:0] arg_reg, inc_reg, mres_reg;
    logic signed [W-1:0] k_reg [STAGES];
    logic [63:0]  ma_reg, mb_reg;
    logic         neg_reg, sh_h_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_valid_reg;
    logic [127:0] acc_reg;
    logic signed [31:0] out_pos_reg, out_vel_reg;

    logic signed [W-1:0] k_sel, arg_h;
    logic [31:0]  a_limb, b_limb;
    logic [127:0] pp_term, q;
    logic [63:0]  limit, mag;
    logic         over;

    assign k_sel  = k_reg[dp_cmd.k_idx];
    assign arg_h  = dp_cmd.pass_y ? sat_neg(arg_reg) : arg_reg;
    assign a_limb = dp_cmd.limb[1] ? ma_reg[63:32] : ma_reg[31:0];
    assign b_limb = dp_cmd.limb[0] ? mb_reg[63:32] : mb_reg[31:0];
    assign pp_term = {64'd0, prod_reg} << {pp_sh_reg, 5'd0};

    // rounding bias is preloaded into the accumulator, so only shift and clip here
    always_comb
    begin
        q     = sh_h_reg ? (acc_reg >> H_SHIFT) : (acc_reg >> COEF_SHIFT);
        limit = MAXMAG + 64'(neg_reg);
        over  = (q[127:64] != '0) || (q[63:0] > limit);
        mag   = over ? limit : q[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            vel_reg      <= VEL_INIT;
            h_reg        <= STEP_RESET;
            pp_valid_reg <= 1'b0;
        end
        else
        begin
            pp_valid_reg <= (dp_cmd.op == DP_PP);
            if (cfg_we)
            begin
                h_reg <= cfg_data;
            end
            if (dp_cmd.op == DP_LOAD)
            begin
                pos_reg <= load_word(load_pos);
                vel_reg <= load_word(load_vel);
            end
            else if (dp_cmd.op == DP_UPDATE)
            begin
                if (dp_cmd.pass_y)
                begin
                    vel_reg <= sat_add(vel_reg, inc_reg);
                end
                else
                begin
                    pos_reg <= sat_add(pos_reg, inc_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pp_valid_reg)
        begin
            acc_reg <= acc_reg + pp_term;
        end
        unique case (dp_cmd.op)
            DP_ARG_INIT:
            begin
                // x pass runs on y, y pass runs on the new x
                arg_reg <= dp_cmd.pass_y ? pos_reg : vel_reg;
            end
            DP_MUL_K:
            begin
                ma_reg   <= mag64(k_sel);
                mb_reg   <= COEF_MAG[dp_cmd.coef_idx];
                neg_reg  <= k_sel[W-1] ^ COEF_NEG[dp_cmd.coef_idx];
                sh_h_reg <= 1'b0;
                acc_reg  <= 128'd1 << (COEF_SHIFT - 1);
            end
            DP_MUL_ARG:
            begin
                ma_reg   <= mag64(arg_h);
                mb_reg   <= 64'(h_reg);
                neg_reg  <= arg_h[W-1];
                sh_h_reg <= 1'b1;
                acc_reg  <= 128'd1 << (H_SHIFT - 1);
            end
            DP_PP:
            begin
                prod_reg  <= 64'(a_limb) * 64'(b_limb);
                pp_sh_reg <= 2'(dp_cmd.limb[1]) + 2'(dp_cmd.limb[0]);
            end
            DP_SAT:
            begin
                mres_reg <= neg_reg ? W'(-mag) : W'(mag);
            end
            DP_ACC_ARG:
            begin
                arg_reg <= sat_add(arg_reg, mres_reg);
            end
            DP_STORE_K:
            begin
                k_reg[dp_cmd.k_idx] <= mres_reg;
                inc_reg             <= '0;
            end
            DP_ACC_INC:
            begin
                inc_reg <= sat_add(inc_reg, mres_reg);
            end
            DP_PUBLISH:
            begin
                out_pos_reg <= out_word(pos_reg);
                out_vel_reg <= out_word(vel_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign pos_value = out_pos_reg;
    assign vel_value = out_vel_reg;

endmodule

### hw/rtl/oscillator_rk_step.sv
// Harmonic oscillator integrator (x' = y, y' = -x), one Dormand-Prince step
// per advance item, seven stages on x then seven on y, combined with the
// fourth-order weights, all in saturating signed fixed point. A load item sets
// x and y. Every item returns one result with both values. One item is
// processed at a time: the next item is accepted only after the result of
// the last one has entered the result slot, which waits while it is full.
// Every multiply uses the single shared 32x32 multiplier: each of the 70
// constant or step multiplies goes through it as four accumulated limb
// products with rounding. step_size may be written at any time the block is
// idle; the cfg channel is always ready.
module oscillator_rk_step #(
    parameter int WORD_BITS = osc_rk_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = osc_rk_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    osc_rk_cmd_if.sink   cmd,
    osc_rk_res_if.source result,
    osc_rk_cfg_if.sink   cfg
);
    import osc_rk_pkg::*;

    dp_cmd_t dp_cmd;

    assign cfg.ready = 1'b1;

    osc_rk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_opcode (cmd.opcode),
        .cmd_ready  (cmd.ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .dp_cmd     (dp_cmd)
    );

    osc_rk_dp #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .load_pos  (cmd.load_pos),
        .load_vel  (cmd.load_vel),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.step_size),
        .pos_value (result.pos_value),
        .vel_value (result.vel_value)
    );

endmodule

### hw/rtl/osc_rk_checker.sv
module osc_rk_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input osc_rk_pkg::opcode_t cmd_opcode,
    input logic signed [31:0]  cmd_load_pos,
    input logic signed [31:0]  cmd_load_vel,
    input logic                res_valid,
    input logic                res_ready,
    input logic signed [31:0]  res_pos,
    input logic signed [31:0]  res_vel
);
    import osc_rk_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_pos) && $stable(res_vel))
        else $error("result item changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item taken while previous still in progress");

    a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_opcode == OP_LOAD) && !res_valid |=> ##1
        res_valid && (res_pos == $past(cmd_load_pos, 2)) &&
        (res_vel == $past(cmd_load_vel, 2)))
        else $error("load item not returned as loaded");

endmodule

bind oscillator_rk_step osc_rk_checker u_osc_rk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_opcode   (cmd.opcode),
    .cmd_load_pos (cmd.load_pos),
    .cmd_load_vel (cmd.load_vel),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_pos      (result.pos_value),
    .res_vel      (result.vel_value)
);
